// ===== rtl/nds_pkg.sv =====
`default_nettype none

package nds_pkg;

  localparam int unsigned INDEX_BITS = 12;
  localparam int unsigned COUNT_BITS = 13;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic load_we;
    logic query_start;
    logic issue;
    logic result_load;
  } nds_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic issue_last;
    logic scan_done;
  } nds_status_t;

endpackage

`default_nettype wire

// ===== rtl/nds_datapath.sv =====
`default_nettype none

module nds_datapath
  import nds_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned COORD_BITS   = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire nds_cmd_t                     cmd,
  output nds_status_t                       status,
  input  wire logic                         cfg_we,
  input  wire logic [COUNT_BITS-1:0]        cfg_wdata,
  input  wire logic [INDEX_BITS-1:0]        vertex_index,
  input  wire logic signed [COORD_BITS-1:0] coord_x,
  input  wire logic signed [COORD_BITS-1:0] coord_y,
  input  wire logic signed [COORD_BITS-1:0] coord_z,
  output logic [INDEX_BITS-1:0]             nearest_index
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned MW = 3 * COORD_BITS;

  logic [COUNT_BITS-1:0] vertex_count;
  logic [CW-1:0]         count_eff;
  logic [CW-1:0]         addr;

  logic [MW-1:0] mem [MAX_VERTICES];
  logic [MW-1:0] rd_q;

  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic signed [COORD_BITS-1:0] rx, ry, rz;

  logic          s1_valid, s2_valid, s3_valid;
  logic          s1_last, s2_last, s3_last;
  logic [AW-1:0] s1_idx, s2_idx, s3_idx;

  logic signed [PW-1:0] px, py, pz;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] best;
  logic [AW-1:0]        best_idx;
  logic                 scan_done;
  logic                 load_hit;

  assign count_eff = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                              : CW'(vertex_count);
  assign load_hit  = cmd.load_we && (32'(vertex_index) < 32'(MAX_VERTICES));

  assign status.count_zero = (count_eff == '0);
  assign status.issue_last = (addr == count_eff - CW'(1));
  assign status.scan_done  = scan_done;

  assign {rx, ry, rz} = rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_BITS'(12);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      mem[AW'(vertex_index)] <= {coord_x, coord_y, coord_z};
    end
    if (cmd.issue) begin
      rd_q <= mem[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx <= coord_x;
      qy <= coord_y;
      qz <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.query_start) begin
      addr <= '0;
    end else if (cmd.issue) begin
      addr <= addr + CW'(1);
    end
  end

  // read -> multiply -> sum -> compare
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      scan_done <= s3_valid && s3_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= addr[AW-1:0];
    s1_last <= status.issue_last;
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s3_idx  <= s2_idx;
    s3_last <= s2_last;
    px      <= rx * qx;
    py      <= ry * qy;
    pz      <= rz * qz;
    sum     <= SW'(px) + SW'(py) + SW'(pz);
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_idx <= '0;
    end else if (s3_valid && (s3_idx == '0 || sum > best)) begin
      best     <= sum;
      best_idx <= s3_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      nearest_index <= INDEX_BITS'(best_idx);
    end
  end

`ifndef ASSERT_OFF
  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (addr < count_eff))
    else $error("scan address beyond vertex count");

  a_start_clears_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.query_start |=> (addr == '0))
    else $error("scan address not cleared at query start");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_last) |=> scan_done)
    else $error("last compare did not end the scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/nds_ctrl.sv =====
`default_nettype none

module nds_ctrl
  import nds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output nds_cmd_t         cmd,
  input  wire nds_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready        = (state == ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign cmd.load_we     = accept && (opcode == OP_LOAD);
  assign cmd.query_start = accept && (opcode == OP_QUERY);
  assign cmd.issue       = (state == ST_SCAN);
  assign cmd.result_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.query_start) begin
            state <= status.count_zero ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (status.scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.result_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    status.scan_done |-> (state == ST_DRAIN))
    else $error("scan done outside drain");

  a_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !status.count_zero)
    else $error("scan with zero vertex count");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> (out_valid && state == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/nearest_direction_search.sv =====
`default_nettype none

// Nearest direction search. Loads (opcode 0) write one vertex direction into
// the table. A query (opcode 1) returns the index of the vertex, among the
// first vertex_count entries, with the largest dot product against the query
// point; the lowest index wins ties, and a zero query or zero count gives
// index 0. The vertex table has one read port and is scanned one entry per
// cycle, followed by a four-stage read/multiply/sum/compare drain. A new
// request is taken only once the previous query has moved its result into the
// output register; loads may proceed while that result waits. Reading a
// never-loaded entry gives an undefined index. vertex_count resets to 12 and
// is clamped to MAX_VERTICES.
module nearest_direction_search
  import nds_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned COORD_BITS   = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [COUNT_BITS-1:0]        cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         opcode,
  input  wire logic [INDEX_BITS-1:0]        vertex_index,
  input  wire logic signed [COORD_BITS-1:0] coord_x,
  input  wire logic signed [COORD_BITS-1:0] coord_y,
  input  wire logic signed [COORD_BITS-1:0] coord_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [INDEX_BITS-1:0]             nearest_index
);

  nds_cmd_t    cmd;
  nds_status_t status;

  nds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  nds_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .vertex_index  (vertex_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .nearest_index (nearest_index)
  );

endmodule

`default_nettype wire
